// ----- sv/wma_pkg.sv -----
// Shared types and constants for the windowed moving average block.
package wma_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 5;
    localparam int CNT_W    = 5;

    localparam logic ACT_ADD     = 1'b0;
    localparam logic ACT_SET_ALL = 1'b1;

    localparam logic [CFG_W-1:0] WLEN_RESET = 5'd16;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [CNT_W-1:0]           held_count;
        logic                       empty_res;
    } out_word_t;

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef struct packed {
        logic add;
        logic set_all;
        logic rotate;
    } cell_ctrl_t;

endpackage

// ----- sv/wma_stream_if.sv -----
// Valid/ready channel carrying one word of type T.
interface wma_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- sv/wma_cell.sv -----
// One cell of the sample chain: a held sample and its occupied flag.
module wma_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wma_pkg::cell_ctrl_t           ctrl,
    input  logic                          keep,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] set_sample,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] prev_sample,
    input  logic                          prev_occ,
    output logic signed [wma_pkg::SAMPLE_W-1:0] sample,
    output logic                          occ
);
    import wma_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       occ_reg;
    logic                       occ_next;

    always_comb
    begin
        sample_next = sample_reg;
        occ_next    = occ_reg;
        if (ctrl.add)
        begin
            sample_next = prev_sample;
            occ_next    = keep;
        end
        else if (ctrl.rotate)
        begin
            sample_next = prev_sample;
            occ_next    = prev_occ;
        end
        else if (ctrl.set_all && occ_reg)
        begin
            sample_next = set_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;
    assign occ    = occ_reg;

endmodule

// ----- sv/wma_div.sv -----
// Restoring divider, one quotient bit a cycle; signed dividend, truncates toward zero.
module wma_div #(
    parameter int SUM_W = 37
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [SUM_W-1:0]             dividend,
    input  logic [wma_pkg::CNT_W-1:0]           divisor,
    output logic                                done,
    output logic signed [wma_pkg::SAMPLE_W-1:0] quotient
);
    import wma_pkg::*;

    localparam int CTR_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic [CTR_W-1:0] ctr_reg;
    logic [CTR_W-1:0] ctr_next;
    logic             neg_reg;
    logic             neg_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   trial_sub;
    logic             fits;
    logic [SUM_W-1:0] quo_signed;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        trial_sub = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        ctr_next  = ctr_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            ctr_next  = CTR_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            ctr_next = ctr_reg - 1'b1;
            if (ctr_reg == CTR_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ctr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ctr_reg  <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[SAMPLE_W-1:0];
    assign done       = done_reg;

endmodule

// ----- sv/windowed_moving_average.sv -----
// Windowed moving average: top level with the cell chain, sum pass and divider.
//
// Channels: samples (sink) takes a word {action, sample}; action add appends
// the sample, dropping the oldest entries beyond the window, action set_all
// overwrites every held entry. results (source) returns one word per input
// word: {average, held_count, empty_res}, the mean truncated toward zero,
// or 0 with empty_res set when nothing is held. cfg (sink) writes
// window_length; 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX.
// Write it only while the block is idle.
// Throughput: one word at a time; no new word is taken until the
// result of the last one is in the output register (the sum is 37 bits
// wide for WINDOW_MAX 16). The time per word is set by one full rotation
// of the cell chain to form the sum and the bit-serial divider, one
// quotient bit per cycle.
// Reset empties the store and sets window_length to 16. When the receiver
// stalls, the finished word waits in the output register; the next input
// word is still taken and processed, and its result waits until the output
// register frees.
module windowed_moving_average #(
    parameter int WINDOW_MAX = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    wma_stream_if.sink   samples,
    wma_stream_if.source results,
    wma_stream_if.sink   cfg
);
    import wma_pkg::*;

    localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW_MAX);
    localparam int STEP_W = $clog2(WINDOW_MAX + 1);
    localparam int WCAP   = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SUM       = 3'd1;
    localparam logic [2:0] ST_DIV_START = 3'd2;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CFG_W-1:0]        wlen_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_word_t               out_data_reg;
    out_word_t               out_data_next;

    logic [CNT_W-1:0]        w_eff;
    logic [CNT_W:0]          count_inc;
    logic [CNT_W-1:0]        count_add;
    logic                    accept;
    logic                    div_start;
    logic                    div_done;
    logic signed [SAMPLE_W-1:0] div_quotient;
    cell_ctrl_t              ctrl;

    logic signed [SAMPLE_W-1:0] cell_sample [WINDOW_MAX];
    logic                       cell_occ    [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      keep;
    logic signed [SAMPLE_W-1:0] head_sample;
    logic signed [SAMPLE_W-1:0] tail_sample;
    logic                       tail_occ;

    assign accept = samples.valid && samples.ready;

    // effective window: zero acts as one, clipped to the chain length
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (wlen_reg > CFG_W'(WCAP))
        begin
            w_eff = CNT_W'(WCAP);
        end
        else
        begin
            w_eff = wlen_reg;
        end
        count_inc = {1'b0, count_reg} + 1'b1;
        count_add = (count_inc > {1'b0, w_eff}) ? w_eff : count_inc[CNT_W-1:0];
    end

    assign tail_sample = cell_sample[WINDOW_MAX-1];
    assign tail_occ    = cell_occ[WINDOW_MAX-1];
    assign head_sample = ctrl.rotate ? tail_sample : samples.data.sample;

    // newest entry at cell 0, oldest at cell count-1
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign keep[i] = (i < int'(count_add));
        if (i == 0)
        begin : g_head
            wma_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .keep        (keep[i]),
                .set_sample  (samples.data.sample),
                .prev_sample (head_sample),
                .prev_occ    (tail_occ),
                .sample      (cell_sample[i]),
                .occ         (cell_occ[i])
            );
        end
        else
        begin : g_body
            wma_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .keep        (keep[i]),
                .set_sample  (samples.data.sample),
                .prev_sample (cell_sample[i-1]),
                .prev_occ    (cell_occ[i-1]),
                .sample      (cell_sample[i]),
                .occ         (cell_occ[i])
            );
        end
    end

    wma_div #(.SUM_W(SUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;
        ctrl           = '0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (samples.data.action == ACT_ADD)
                    begin
                        ctrl.add   = 1'b1;
                        count_next = count_add;
                    end
                    else
                    begin
                        ctrl.set_all = 1'b1;
                    end
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // one full turn of the chain brings every entry past the tail
                ctrl.rotate = 1'b1;
                if (tail_occ)
                begin
                    acc_next = acc_reg + SUM_W'(tail_sample);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(WINDOW_MAX - 1))
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.average    = (count_reg == '0) ? '0 : div_quotient;
                    out_data_next.held_count = count_reg;
                    out_data_next.empty_res  = (count_reg == '0);
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wlen_reg      <= WLEN_RESET;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                wlen_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

// ----- sv/wma_checker.sv -----
// Port-level checks for the windowed moving average, bound to the top level.
module wma_checker #(
    parameter int WMAX = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic signed [wma_pkg::SAMPLE_W-1:0] res_average,
    input logic [wma_pkg::CNT_W-1:0]           res_count,
    input logic                                res_empty
);
    import wma_pkg::*;

    // a result word held back by the receiver stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_average)
        && $stable(res_count) && $stable(res_empty))
        else $error("result word changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (int'(res_count) <= WMAX))
        else $error("held count beyond chain length");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_empty == (res_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_avg: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_empty |-> (res_average == '0))
        else $error("non-zero average on empty store");

endmodule

bind windowed_moving_average wma_checker #(.WMAX(WINDOW_MAX)) u_wma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .res_average (results.data.average),
    .res_count   (results.data.held_count),
    .res_empty   (results.data.empty_res)
);
